// ===== rtl/blof_pkg.sv =====
package blof_pkg;

    // Default ring depth and the fixed pre-fill mean (four entries, divide by four).
    localparam int unsigned WINDOW_DEPTH_DEF = 5;
    localparam int unsigned PREFILL_COUNT    = 4;
    localparam int unsigned PREFILL_SHIFT    = 2;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [DATA_W-1:0] MARGIN_RESET = 8'd5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WARNING_LEVEL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_MARGIN = 2'd2;

    // Status codes.
    localparam logic [1:0] STATUS_NORMAL = 2'd0;
    localparam logic [1:0] STATUS_WARN   = 2'd1;
    localparam logic [1:0] STATUS_STOP   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIX_HI,
        ST_FIX_LO,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/battery_level_outlier_filter_unit.sv =====
// Battery level outlier filter. Each input beat carries one 8-bit battery reading, which is
// written into a ring of WINDOW_DEPTH entries, and each input beat yields exactly one result
// beat. Until the ring has been filled once, the result carries the raw reading with normal
// status, while the running average is the truncated mean of the first four ring entries.
// From the beat that fills the ring onward, the first maximum and the first minimum entry are
// replaced by the previous average when they stray more than outlier_margin from it, and the
// whole ring is averaged with truncation and checked against warning_level and stop_level
// (stop wins over warning). One small sequencer does all the work through a single ring read
// port: a scan for the extremes, a fix-up of the maximum and then of the minimum, a summing
// pass and a step that divides the sum by the ring depth through a reciprocal multiplication;
// a pre-fill beat skips the scan, the fix-ups and the division and sums only the first four
// entries. The input is not ready while a beat is in work; the result register is separate,
// so a new beat is accepted while the previous result still waits to be taken. Configuration
// registers are written through a plain write port and should only be changed while the
// block is idle.
module battery_level_outlier_filter_unit #(
    parameter int unsigned WINDOW_DEPTH = blof_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               cfg_we,
    input  logic [blof_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [blof_pkg::DATA_W-1:0]        cfg_wdata,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [blof_pkg::DATA_W-1:0]        s_sample,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [1:0]                         m_status,
    output logic [blof_pkg::DATA_W-1:0]        m_level,
    output logic                               m_window_full
);

    localparam int unsigned DW        = blof_pkg::DATA_W;
    localparam int unsigned IDX_W     = $clog2(WINDOW_DEPTH);
    localparam int unsigned SUM_W     = $clog2(255 * WINDOW_DEPTH + 1);
    localparam int unsigned PRE_COUNT = (WINDOW_DEPTH < blof_pkg::PREFILL_COUNT) ?
                                        WINDOW_DEPTH : blof_pkg::PREFILL_COUNT;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [IDX_W-1:0] PRE_LAST = IDX_W'(PRE_COUNT - 1);

    // The ring mean is sum * RECIP >> RECIP_SH, with RECIP = 2^RECIP_SH / WINDOW_DEPTH rounded
    // up. The rounding error of RECIP is below WINDOW_DEPTH and the sum is below 2^SUM_W, so
    // this shift keeps the product exact to the truncated quotient for every reachable sum.
    localparam int unsigned RECIP_SH = SUM_W + IDX_W;
    localparam int unsigned PROD_W   = SUM_W + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP =
        RECIP_SH'(((1 << RECIP_SH) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

    // Configuration registers.
    logic [DW-1:0] warning_level_reg;
    logic [DW-1:0] stop_level_reg;
    logic [DW-1:0] margin_reg;

    // Ring and its bookkeeping.
    logic [DW-1:0]    window_reg [WINDOW_DEPTH];
    logic [IDX_W-1:0] wr_idx_reg;
    logic             filled_reg;
    logic [DW-1:0]    avg_reg;

    // Sequencer and shared datapath.
    blof_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] hi_idx_reg, lo_idx_reg;
    logic [DW-1:0]    hi_val_reg, lo_val_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [DW-1:0]    sample_reg;

    // Result register.
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [DW-1:0]    m_level_reg;
    logic             m_full_reg;

    logic              in_fire;
    logic              out_free;
    logic [DW-1:0]     rd_data;
    logic [SUM_W-1:0]  sum_add;
    logic [PROD_W-1:0] div_prod;
    logic              hi_hit, lo_hit;
    logic [IDX_W-1:0]  sum_last;
    logic [1:0]        status_calc;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_data  = window_reg[idx_reg];
    assign sum_add  = sum_reg + SUM_W'(rd_data);
    assign div_prod = {{RECIP_SH{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP};
    assign sum_last = filled_reg ? LAST_IDX : PRE_LAST;

    // The margin comparisons are done one bit wider so that avg + margin never wraps, and the
    // lower test is written as lo + margin < avg so that avg - margin never goes negative.
    assign hi_hit = ({1'b0, hi_val_reg} > ({1'b0, avg_reg} + {1'b0, margin_reg}));
    assign lo_hit = (({1'b0, lo_val_reg} + {1'b0, margin_reg}) < {1'b0, avg_reg});

    always_comb begin
        status_calc = blof_pkg::STATUS_NORMAL;
        if (filled_reg && (avg_reg < warning_level_reg)) begin
            status_calc = (avg_reg <= stop_level_reg) ? blof_pkg::STATUS_STOP
                                                      : blof_pkg::STATUS_WARN;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            blof_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = blof_pkg::ST_SCAN;
                end
            end
            blof_pkg::ST_SCAN: begin
                // Before the ring is full, the scan pass is skipped straight to summing.
                if (!filled_reg) begin
                    state_next = blof_pkg::ST_SUM;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = blof_pkg::ST_FIX_HI;
                end
            end
            blof_pkg::ST_FIX_HI: begin
                state_next = blof_pkg::ST_FIX_LO;
            end
            blof_pkg::ST_FIX_LO: begin
                state_next = blof_pkg::ST_SUM;
            end
            blof_pkg::ST_SUM: begin
                if (idx_reg == sum_last) begin
                    state_next = filled_reg ? blof_pkg::ST_DIV : blof_pkg::ST_DONE;
                end
            end
            blof_pkg::ST_DIV: begin
                state_next = blof_pkg::ST_DONE;
            end
            blof_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = blof_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = blof_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= blof_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warning_level_reg <= '0;
            stop_level_reg    <= '0;
            margin_reg        <= blof_pkg::MARGIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                blof_pkg::REG_WARNING_LEVEL:  warning_level_reg <= cfg_wdata;
                blof_pkg::REG_STOP_LEVEL:     stop_level_reg    <= cfg_wdata;
                blof_pkg::REG_OUTLIER_MARGIN: margin_reg        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Ring contents and the running state that survives from beat to beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                window_reg[i] <= '0;
            end
            wr_idx_reg <= '0;
            filled_reg <= 1'b0;
            avg_reg    <= '0;
        end else begin
            case (state_reg)
                blof_pkg::ST_IDLE: begin
                    if (in_fire) begin
                        window_reg[wr_idx_reg] <= s_sample;
                        if (wr_idx_reg == LAST_IDX) begin
                            wr_idx_reg <= '0;
                            filled_reg <= 1'b1;
                        end else begin
                            wr_idx_reg <= wr_idx_reg + 1'b1;
                        end
                    end
                end
                blof_pkg::ST_FIX_HI: begin
                    if (hi_hit) begin
                        window_reg[hi_idx_reg] <= avg_reg;
                    end
                end
                blof_pkg::ST_FIX_LO: begin
                    if (lo_hit) begin
                        window_reg[lo_idx_reg] <= avg_reg;
                    end
                end
                blof_pkg::ST_SUM: begin
                    if (!filled_reg && (idx_reg == sum_last)) begin
                        avg_reg <= DW'(sum_add >> blof_pkg::PREFILL_SHIFT);
                    end
                end
                blof_pkg::ST_DIV: begin
                    avg_reg <= div_prod[RECIP_SH +: DW];
                end
                default: begin
                end
            endcase
        end
    end

    // Shared scan and sum datapath; no reset needed.
    always_ff @(posedge aclk) begin
        case (state_reg)
            blof_pkg::ST_IDLE: begin
                idx_reg <= '0;
                sum_reg <= '0;
                if (in_fire) begin
                    sample_reg <= s_sample;
                end
            end
            blof_pkg::ST_SCAN: begin
                // First maximum and first minimum: only a strict improvement moves them.
                if (idx_reg == '0) begin
                    hi_idx_reg <= '0;
                    lo_idx_reg <= '0;
                    hi_val_reg <= rd_data;
                    lo_val_reg <= rd_data;
                end else begin
                    if (rd_data > hi_val_reg) begin
                        hi_idx_reg <= idx_reg;
                        hi_val_reg <= rd_data;
                    end
                    if (rd_data < lo_val_reg) begin
                        lo_idx_reg <= idx_reg;
                        lo_val_reg <= rd_data;
                    end
                end
                if (!filled_reg || (idx_reg == LAST_IDX)) begin
                    idx_reg <= '0;
                end else begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            blof_pkg::ST_FIX_HI: begin
                // When the maximum and minimum are the same entry, the minimum check must see
                // the value the maximum check left behind.
                if (hi_hit && (hi_idx_reg == lo_idx_reg)) begin
                    lo_val_reg <= avg_reg;
                end
            end
            blof_pkg::ST_SUM: begin
                sum_reg <= sum_add;
                idx_reg <= idx_reg + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if ((state_reg == blof_pkg::ST_DONE) && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == blof_pkg::ST_DONE) && out_free) begin
            m_status_reg <= status_calc;
            m_level_reg  <= filled_reg ? avg_reg : sample_reg;
            m_full_reg   <= filled_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_level       = m_level_reg;
    assign m_window_full = m_full_reg;

    // A new result appears only when the sequencer finishes a beat.
    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == blof_pkg::ST_DONE))
        else $error("result appeared without a finished beat");

    // An alarm status is only possible once the ring has been filled.
    a_status_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_status_reg != blof_pkg::STATUS_NORMAL) |-> m_full_reg)
        else $error("alarm status reported before the ring was full");

    // The write pointer always stays inside the ring.
    a_wr_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_idx_reg <= LAST_IDX)
        else $error("ring write pointer out of range");

    // After accepting a beat the block is busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("input ready right after accepting a beat");

endmodule

// ===== test/battery_level_outlier_filter_unit_tb.sv =====
module battery_level_outlier_filter_unit_tb;

    localparam int unsigned DEPTH = blof_pkg::WINDOW_DEPTH_DEF;

    // One filtered reading as the result channel carries it.
    typedef struct packed {
        logic [1:0]                  status;
        logic [blof_pkg::DATA_W-1:0] level;
        logic                        full;
    } reading_t;

    // Clock, reset and every DUT input start at a known value at time zero.
    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [blof_pkg::CFG_IDX_W-1:0] cfg_index = blof_pkg::REG_WARNING_LEVEL;
    logic [blof_pkg::DATA_W-1:0]    cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic [blof_pkg::DATA_W-1:0]    s_sample  = '0;
    logic                           m_ready   = 1'b0;

    logic                           s_ready;
    logic                           m_valid;
    logic [1:0]                     m_status;
    logic [blof_pkg::DATA_W-1:0]    m_level;
    logic                           m_window_full;

    // Chance, in percent, that the sender idles or the receiver stalls on a given cycle.
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    int unsigned error_count = 0;

    // Readings the DUT still owes us, oldest first.
    reading_t expected_readings[$];

    // Shadow copy of the filter: ring, write pointer, fill flag, running average and
    // the three threshold registers, all at their reset values.
    logic [blof_pkg::DATA_W-1:0] ring_copy [DEPTH];
    int unsigned                 ring_pos     = 0;
    bit                          ring_filled  = 1'b0;
    logic [blof_pkg::DATA_W-1:0] running_avg  = '0;
    logic [blof_pkg::DATA_W-1:0] warn_level   = '0;
    logic [blof_pkg::DATA_W-1:0] stop_level   = '0;
    logic [blof_pkg::DATA_W-1:0] margin_level = blof_pkg::MARGIN_RESET;

    // Center of the random battery trace; most samples hover around it.
    int baseline = 128;

    battery_level_outlier_filter_unit #(
        .WINDOW_DEPTH (DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_level       (m_level),
        .m_window_full (m_window_full)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Synchronous reset, held low from time zero and released once.
    initial begin
        for (int i = 0; i < DEPTH; i++) begin
            ring_copy[i] = '0;
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Receiver back-pressure. Ready changes only at rising edges, so it is stable
    // from one edge to the next.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Computes the reading that one accepted sample produces and advances the shadow
    // state. Until the ring has wrapped once, the raw sample goes out with normal
    // status and the average is the plain mean of the first four slots. From the
    // filling beat on, the first maximum and first minimum are pulled back to the
    // previous average when they stray past the margin, then the ring is averaged.
    function automatic reading_t filter_reading(logic [blof_pkg::DATA_W-1:0] sample);
        reading_t    r;
        int          hi;
        int          lo;
        int          prev;
        int          margin;
        int unsigned sum;
        int          i;
        ring_copy[ring_pos] = sample;
        ring_pos++;
        if (ring_pos >= DEPTH) begin
            ring_pos    = 0;
            ring_filled = 1'b1;
        end
        r.status = blof_pkg::STATUS_NORMAL;
        r.level  = sample;
        sum      = 0;
        if (ring_filled) begin
            hi = 0;
            lo = 0;
            for (i = 1; i < DEPTH; i++) begin
                if (ring_copy[i] > ring_copy[hi]) hi = i;
                if (ring_copy[i] < ring_copy[lo]) lo = i;
            end
            // The bounds are plain signed integers, so a wide margin never wraps.
            prev   = running_avg;
            margin = margin_level;
            if (int'(ring_copy[hi]) > prev + margin) ring_copy[hi] = running_avg;
            // With a flat ring hi and lo are the same slot; this test sees the
            // value the maximum check may just have written.
            if (int'(ring_copy[lo]) < prev - margin) ring_copy[lo] = running_avg;
            for (i = 0; i < DEPTH; i++) begin
                sum += ring_copy[i];
            end
            running_avg = blof_pkg::DATA_W'(sum / DEPTH);
            r.level     = running_avg;
            // Stop outranks warning.
            if (running_avg < warn_level) begin
                r.status = (running_avg <= stop_level) ? blof_pkg::STATUS_STOP
                                                       : blof_pkg::STATUS_WARN;
            end
        end else begin
            for (i = 0; i < blof_pkg::PREFILL_COUNT && i < DEPTH; i++) begin
                sum += ring_copy[i];
            end
            running_avg = blof_pkg::DATA_W'(sum / blof_pkg::PREFILL_COUNT);
        end
        r.full = ring_filled;
        return r;
    endfunction

    // Result checker. Everything is sampled at the falling edge, where valid, ready
    // and the payload are stable; a beat seen here is taken at the next rising edge.
    always @(negedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                $display("%0t: unexpected result beat: status %0d level %0d full %0d",
                         $time, m_status, m_level, m_window_full);
                error_count++;
            end else begin
                want = expected_readings.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_status);
                    error_count++;
                end
                if (m_level !== want.level) begin
                    $display("%0t: level mismatch: expected %0d, actual %0d",
                             $time, want.level, m_level);
                    error_count++;
                end
                if (m_window_full !== want.full) begin
                    $display("%0t: window_full mismatch: expected %0d, actual %0d",
                             $time, want.full, m_window_full);
                    error_count++;
                end
            end
        end
    end

    // Writes all three threshold registers on consecutive edges and mirrors them in
    // the shadow copy. Only called while the filter is idle.
    task automatic set_thresholds(input logic [blof_pkg::DATA_W-1:0] warn,
                                  input logic [blof_pkg::DATA_W-1:0] stop,
                                  input logic [blof_pkg::DATA_W-1:0] margin);
        cfg_we    <= 1'b1;
        cfg_index <= blof_pkg::REG_WARNING_LEVEL;
        cfg_wdata <= warn;
        @(posedge aclk);
        cfg_index <= blof_pkg::REG_STOP_LEVEL;
        cfg_wdata <= stop;
        @(posedge aclk);
        cfg_index <= blof_pkg::REG_OUTLIER_MARGIN;
        cfg_wdata <= margin;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        warn_level   = warn;
        stop_level   = stop;
        margin_level = margin;
    endtask

    // Sends one sample beat. Valid may be dropped first on random idle cycles; once raised
    // for the beat it stays high until taken, and the caller lowers it when the stream pauses.
    task automatic send_sample(input logic [blof_pkg::DATA_W-1:0] sample);
        bit taken;
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= sample;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        expected_readings.push_back(filter_reading(sample));
    endtask

    // Drops valid and waits until every owed reading has come back.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (expected_readings.size() != 0);
    endtask

    // Full quiesce before a register write: drained, then a wait longer than a full-ring beat.
    task automatic settle();
        hold_until_drained();
        repeat (30) @(posedge aclk);
    endtask

    // The first samples after reset: pre-fill beats carry the raw reading, and the
    // fifth one, which writes the last slot, already reports the filtered average.
    task automatic test_ring_fill();
        set_thresholds(8'd0, 8'd0, blof_pkg::MARGIN_RESET);
        send_sample(8'd0);
        send_sample(8'd255);
        send_sample(8'd128);
        send_sample(8'd64);
        send_sample(8'd200);
        settle();
    endtask

    // A ring of identical samples makes the maximum and minimum the same slot. A zero margin
    // is the tightest setting; a top warning level flags every average below full scale.
    task automatic test_flat_ring();
        set_thresholds(8'd255, 8'd0, 8'd0);
        repeat (5) send_sample(8'd77);
        settle();
    endtask

    // The widest margin pushes the bounds past the sample range on both sides, so
    // nothing is ever replaced even for full-scale swings.
    task automatic test_margin_limits();
        set_thresholds(8'd0, 8'd0, 8'd255);
        send_sample(8'd0);
        send_sample(8'd255);
        send_sample(8'd0);
        send_sample(8'd255);
        settle();
    endtask

    // Walks the average down into the stop band and back up into the warning band,
    // then checks that a stop level above the warning level never fires.
    task automatic test_status_levels();
        set_thresholds(8'd200, 8'd100, 8'd255);
        send_sample(8'd0);
        send_sample(8'd0);
        send_sample(8'd0);
        send_sample(8'd150);
        send_sample(8'd150);
        send_sample(8'd150);
        send_sample(8'd255);
        send_sample(8'd255);
        settle();
        set_thresholds(8'd0, 8'd255, 8'd255);
        send_sample(8'd0);
        send_sample(8'd255);
        settle();
    endtask

    function automatic int clamp_byte(int v);
        return (v < 0) ? 0 : ((v > 255) ? 255 : v);
    endfunction

    // Battery-like trace: mostly small wander around a drifting baseline, some
    // spikes just past the margin to trigger the outlier fix, some pure noise.
    function automatic logic [blof_pkg::DATA_W-1:0] next_sample();
        int pick;
        int v;
        pick = $urandom_range(99);
        if (pick < 5) begin
            baseline = $urandom_range(255);
        end else if (pick < 50) begin
            baseline = clamp_byte(baseline + int'($urandom_range(6)) - 3);
        end
        pick = $urandom_range(99);
        if (pick < 65) begin
            v = baseline + int'($urandom_range(8)) - 4;
        end else if (pick < 85) begin
            v = int'(margin_level) + int'($urandom_range(40)) + 1;
            v = ($urandom_range(1) == 1) ? baseline + v : baseline - v;
        end else begin
            v = $urandom_range(255);
        end
        return blof_pkg::DATA_W'(clamp_byte(v));
    endfunction

    // Threshold that is usually near the trace, sometimes at a range extreme.
    function automatic logic [blof_pkg::DATA_W-1:0] pick_level(int center);
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        return blof_pkg::DATA_W'(clamp_byte(center + int'($urandom_range(40)) - 20));
    endfunction

    function automatic logic [blof_pkg::DATA_W-1:0] pick_margin();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2, 3:    return blof_pkg::DATA_W'($urandom_range(15));
            default: return blof_pkg::DATA_W'($urandom_range(255));
        endcase
    endfunction

    // Random traffic under one idling pattern: batches of samples, each under a
    // freshly written threshold set, with an occasional full drain mid-batch.
    task automatic test_random_traffic(input int unsigned send_pct,
                                       input int unsigned recv_pct,
                                       input int unsigned beats);
        logic [blof_pkg::DATA_W-1:0] warn;
        int unsigned                 sent;
        sender_idle_pct    = send_pct;
        receiver_stall_pct = recv_pct;
        sent = 0;
        while (sent < beats) begin
            warn = pick_level(baseline);
            set_thresholds(warn, pick_level(int'(warn) - 15), pick_margin());
            for (int k = 0; k < 64 && sent < beats; k++) begin
                if ($urandom_range(49) == 0) begin
                    hold_until_drained();
                end
                send_sample(next_sample());
                sent++;
            end
            settle();
        end
    endtask

    initial begin
        @(posedge aresetn);
        @(posedge aclk);
        test_ring_fill();
        test_flat_ring();
        test_margin_limits();
        test_status_levels();
        // Idling patterns: none, sender only, receiver only, then both.
        test_random_traffic(0, 0, 256);
        test_random_traffic(48, 0, 256);
        test_random_traffic(0, 48, 256);
        test_random_traffic(33, 33, 256);
        settle();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/blof_pkg.sv
rtl/battery_level_outlier_filter_unit.sv
test/battery_level_outlier_filter_unit_tb.sv
